### rtl/hmf_pkg.sv
`timescale 1ns / 1ps
package hmf_pkg;
    localparam int LengthBitsDefault = 32;

    localparam logic [3:0] PART_FRAME  = 4'd0;
    localparam logic [3:0] PART_METHOD = 4'd1;
    localparam logic [3:0] PART_TARGET = 4'd2;
    localparam logic [3:0] PART_VER    = 4'd3;
    localparam logic [3:0] PART_CODE   = 4'd4;
    localparam logic [3:0] PART_REASON = 4'd5;
    localparam logic [3:0] PART_HDR    = 4'd6;
    localparam logic [3:0] PART_BLANK  = 4'd7;
    localparam logic [3:0] PART_BODY   = 4'd8;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_PREFIX = 3'd1;
    localparam logic [2:0] ERR_DIGIT  = 3'd2;
    localparam logic [2:0] ERR_EOL    = 3'd3;
    localparam logic [2:0] ERR_NOLF   = 3'd4;
    localparam logic [2:0] ERR_NEG    = 3'd5;

    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_CONN  = 3'd1;
    localparam logic [2:0] KIND_CLEN  = 3'd2;
    localparam logic [2:0] KIND_TENC  = 3'd3;
    localparam logic [2:0] KIND_EXP   = 3'd4;

    localparam logic REG_REQUEST_MODE = 1'b0;
    localparam logic REG_CONTINUE     = 1'b1;

    localparam logic [1:0] STAGE_FIRST = 2'd0;
    localparam logic [1:0] STAGE_HDR   = 2'd1;
    localparam logic [1:0] STAGE_BODY  = 2'd2;
    localparam logic [1:0] STAGE_CHUNK = 2'd3;

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;
    localparam logic [7:0] CH_SP = 8'd32;
    localparam logic [7:0] CH_HT = 8'd9;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [3:0] part;
        logic [2:0] header_kind;
        logic       line_end;
        logic [9:0] status_code;
        logic       message_done;
        logic       close_required;
        logic [2:0] error_code;
    } result_t;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        to_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) digit_of = 5'(c - 8'h30);
        else if (c >= 8'h41 && c <= 8'h46) digit_of = 5'(c - 8'h41 + 8'd10);
        else if (c >= 8'h61 && c <= 8'h66) digit_of = 5'(c - 8'h61 + 8'd10);
        else digit_of = 5'd16;
    endfunction

    function automatic logic [4:0] name_len(input logic [1:0] cand);
        unique case (cand)
            2'd0: name_len = 5'd10;
            2'd1: name_len = 5'd14;
            2'd2: name_len = 5'd17;
            default: name_len = 5'd6;
        endcase
    endfunction

    // Header name characters, lower case, by candidate and position
    function automatic logic [7:0] name_char(input logic [1:0] cand, input logic [4:0] pos);
        logic [135:0] s;
        logic [4:0]   n;
        logic [7:0]   sh;
        unique case (cand)
            2'd0: s = 136'("connection");
            2'd1: s = 136'("content-length");
            2'd2: s = 136'("transfer-encoding");
            default: s = 136'("expect");
        endcase
        n  = name_len(cand);
        sh = {n - 5'd1 - pos, 3'd0};
        name_char = (pos < n) ? 8'(s >> sh) : 8'd0;
    endfunction

    function automatic logic [3:0] value_len(input logic [1:0] cand);
        unique case (cand)
            2'd0: value_len = 4'd5;
            2'd1: value_len = 4'd0;
            2'd2: value_len = 4'd7;
            default: value_len = 4'd12;
        endcase
    endfunction

    function automatic logic [7:0] value_char(input logic [1:0] cand, input logic [3:0] pos);
        logic [95:0] s;
        logic [3:0]  n;
        logic [6:0]  sh;
        unique case (cand)
            2'd0: s = 96'("close");
            2'd1: s = '0;
            2'd2: s = 96'("chunked");
            default: s = 96'("100-continue");
        endcase
        n  = value_len(cand);
        sh = {n - 4'd1 - pos, 3'd0};
        value_char = (pos < n) ? 8'(s >> sh) : 8'd0;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [4:0] pos);
        unique case (pos)
            5'd0: prefix_char = 8'h48;
            5'd1: prefix_char = 8'h54;
            5'd2: prefix_char = 8'h54;
            5'd3: prefix_char = 8'h50;
            5'd4: prefix_char = 8'h2F;
            default: prefix_char = 8'h00;
        endcase
    endfunction
endpackage

### rtl/hmf_core.sv
`timescale 1ns / 1ps
module hmf_core
    import hmf_pkg::*;
#(
    parameter int LENGTH_BITS = LengthBitsDefault
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] b,
    input  logic       request_mode,
    input  logic [1:0] continue_policy,
    output result_t    res
);
    localparam logic [LENGTH_BITS-1:0] LenMax = '1;

    logic [1:0]             stage_reg, stage_next;
    logic [3:0]             phase_reg, phase_next;
    logic [4:0]             npos_reg, npos_next;
    logic [3:0]             cand_reg, cand_next;
    logic [3:0]             vpos_reg, vpos_next;
    logic [LENGTH_BITS-1:0] num_reg, num_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [9:0]             code_reg, code_next;
    logic close_reg, close_next, chunk_reg, chunk_next, exp_reg, exp_next;
    logic cont_reg, cont_next, vbeg_reg, vbeg_next, neg_reg, neg_next;
    logic [2:0] err_reg, err_next;

    logic [4:0] dig;
    logic [LENGTH_BITS+3:0] dec_prod, hex_prod;
    logic [LENGTH_BITS-1:0] dec_acc, hex_acc;
    logic [13:0] code_prod;
    logic [9:0]  code_sum;
    logic        eol;
    logic [2:0]  win;
    logic [7:0]  lb;
    result_t r;
    logic [2:0]  err;

    assign lb  = to_lower(b);
    assign dig = digit_of(b);
    assign eol = (b == CH_CR) || (b == CH_LF);
    assign win = cand_reg[0] ? 3'd0 : cand_reg[1] ? 3'd1 : cand_reg[2] ? 3'd2 :
                 cand_reg[3] ? 3'd3 : 3'd4;

    // Saturating constant-base accumulators
    assign dec_prod = {4'd0, num_reg} * 10 + (LENGTH_BITS+4)'(dig);
    assign hex_prod = {num_reg, 4'd0} + (LENGTH_BITS+4)'(dig);
    assign dec_acc  = (dec_prod > {4'd0, LenMax}) ? LenMax : dec_prod[LENGTH_BITS-1:0];
    assign hex_acc  = (hex_prod > {4'd0, LenMax}) ? LenMax : hex_prod[LENGTH_BITS-1:0];
    assign code_prod = {4'd0, code_reg} * 10 + 14'(dig);
    assign code_sum  = (code_prod > 14'd999) ? 10'd999 : code_prod[9:0];

    always_comb
    begin
        logic [3:0] cn;
        logic       hstart;
        stage_next = stage_reg; phase_next = phase_reg; npos_next = npos_reg;
        cand_next = cand_reg; vpos_next = vpos_reg; num_next = num_reg;
        rem_next = rem_reg; code_next = code_reg; close_next = close_reg;
        chunk_next = chunk_reg; exp_next = exp_reg; cont_next = cont_reg;
        vbeg_next = vbeg_reg; neg_next = neg_reg; err_next = err_reg;
        r = '0; r.byte_out = b; err = ERR_NONE; hstart = 1'b0; cn = cand_reg;
        if (err_reg != ERR_NONE)
        begin
            r.error_code = err_reg;
        end
        else
        begin
            unique case (stage_reg)
                STAGE_FIRST:
                begin
                    logic waitlf;
                    waitlf = 1'b0;
                    if (request_mode)
                    begin
                        if (phase_reg == 4'd0 || phase_reg == 4'd1)
                        begin
                            if (b == CH_SP)
                            begin
                                phase_next = phase_reg + 4'd1; npos_next = '0;
                            end
                            else if (eol) err = ERR_EOL;
                            else r.part = phase_reg + 4'd1;
                        end
                        else if (phase_reg == 4'd2)
                        begin
                            if (npos_reg > 5'd4 || b != prefix_char(npos_reg)) err = ERR_PREFIX;
                            else
                            begin
                                r.part = PART_VER; npos_next = npos_reg + 5'd1;
                                if (npos_reg == 5'd4) phase_next = 4'd3;
                            end
                        end
                        else if (phase_reg == 4'd3)
                        begin
                            if (b == CH_CR) phase_next = 4'd4;
                            else r.part = PART_VER;
                        end
                        else waitlf = 1'b1;
                    end
                    else
                    begin
                        if (phase_reg == 4'd0)
                        begin
                            if (npos_reg > 5'd4 || b != prefix_char(npos_reg)) err = ERR_PREFIX;
                            else
                            begin
                                r.part = PART_VER; npos_next = npos_reg + 5'd1;
                                if (npos_reg == 5'd4) phase_next = 4'd1;
                            end
                        end
                        else if (phase_reg == 4'd1)
                        begin
                            if (b == CH_SP) phase_next = 4'd2;
                            else if (eol) err = ERR_EOL;
                            else r.part = PART_VER;
                        end
                        else if (phase_reg == 4'd2 || phase_reg == 4'd3)
                        begin
                            if (b == CH_SP) phase_next = 4'd4;
                            else if (eol) err = ERR_EOL;
                            else if (phase_reg == 4'd2 && b == 8'h2B)
                            begin
                                r.part = PART_CODE; phase_next = 4'd3;
                            end
                            else if (dig >= 5'd10) err = ERR_DIGIT;
                            else
                            begin
                                code_next = code_sum; r.part = PART_CODE; phase_next = 4'd3;
                            end
                        end
                        else if (phase_reg == 4'd4)
                        begin
                            if (b == CH_CR) phase_next = 4'd5;
                            else r.part = PART_REASON;
                        end
                        else waitlf = 1'b1;
                    end
                    if (waitlf)
                    begin
                        if (b != CH_LF) err = ERR_NOLF;
                        else
                        begin
                            r.line_end = 1'b1;
                            if (!request_mode) r.status_code = code_reg;
                            stage_next = STAGE_HDR; phase_next = '0;
                            npos_next = '0; cand_next = 4'hF;
                        end
                    end
                end
                STAGE_HDR:
                begin
                    if (phase_reg == 4'd1) hstart = 1'b0;
                    if (phase_reg == 4'd2)
                    begin
                        if (b == CH_CR) phase_next = 4'd3;
                        else
                        begin
                            r.part = PART_HDR;
                            if (!vbeg_reg && b == CH_SP)
                            begin
                            end
                            else
                            begin
                                vbeg_next = 1'b1;
                                if (win == 3'd1)
                                begin
                                    if (vpos_reg == 4'd0 && (b == 8'h2D || b == 8'h2B))
                                    begin
                                        neg_next = (b == 8'h2D); vpos_next = 4'd1;
                                    end
                                    else
                                    begin
                                        vpos_next = 4'd1;
                                        if (dig >= 5'd10) err = ERR_DIGIT;
                                        else num_next = dec_acc;
                                    end
                                end
                                else if (win < 3'd4 && vpos_reg < value_len(win[1:0]))
                                begin
                                    if (lb == value_char(win[1:0], vpos_reg))
                                        vpos_next = vpos_reg + 4'd1;
                                    else vpos_next = 4'd15;
                                end
                            end
                        end
                    end
                    else if (phase_reg == 4'd3)
                    begin
                        if (b != CH_LF) err = ERR_NOLF;
                        else phase_next = 4'd4;
                    end
                    else if (phase_reg == 4'd4)
                    begin
                        if (b == CH_SP || b == CH_HT)
                        begin
                            cont_next = 1'b1; phase_next = 4'd2;
                        end
                        else
                        begin
                            logic [2:0] kind;
                            kind = KIND_OTHER;
                            if (win == 3'd0)
                            begin
                                kind = KIND_CONN;
                                if (vpos_reg == 4'd5) close_next = 1'b1;
                            end
                            else if (win == 3'd1)
                            begin
                                kind = KIND_CLEN;
                                if (neg_reg && num_reg != '0) err = ERR_NEG;
                                else rem_next = num_reg;
                            end
                            else if (win == 3'd2)
                            begin
                                kind = KIND_TENC;
                                if (vpos_reg == 4'd7) chunk_next = 1'b1;
                            end
                            else if (win == 3'd3 && vpos_reg == 4'd12 && continue_policy != 2'd0)
                            begin
                                kind = KIND_EXP; exp_next = 1'b1;
                            end
                            r.header_kind = kind; r.line_end = 1'b1; cont_next = 1'b0;
                            if (err == ERR_NONE) hstart = 1'b1;
                        end
                    end
                    else if (phase_reg == 4'd5)
                    begin
                        if (b != CH_LF) err = ERR_NOLF;
                        else
                        begin
                            r.part = PART_BLANK;
                            if ((exp_next && continue_policy >= 2'd2) ||
                                (rem_next == '0 && !chunk_next))
                                r.message_done = 1'b1;
                            else if (chunk_next)
                            begin
                                stage_next = STAGE_CHUNK; phase_next = '0; num_next = '0;
                            end
                            else
                            begin
                                stage_next = STAGE_BODY; phase_next = '0;
                            end
                        end
                    end
                    else if (phase_reg == 4'd1) hstart = 1'b0;
                    else hstart = 1'b1;

                    // Line start: blank line or a fresh header name
                    if (hstart)
                    begin
                        if (b == CH_CR)
                        begin
                            r.part = PART_BLANK; phase_next = 4'd5;
                        end
                        else
                        begin
                            phase_next = 4'd1; cand_next = 4'hF; cn = 4'hF;
                            vpos_next = '0; vbeg_next = 1'b0; neg_next = 1'b0;
                            num_next = '0; cont_next = 1'b0;
                        end
                    end
                    // Header name byte
                    if ((phase_reg == 4'd1 || (hstart && b != CH_CR)) && err == ERR_NONE)
                    begin
                        logic [4:0] p;
                        p = hstart ? 5'd0 : npos_reg;
                        if (eol) err = ERR_EOL;
                        else
                        begin
                            r.part = PART_HDR;
                            for (int i = 0; i < 4; i++)
                            begin
                                if (b == 8'h3A)
                                begin
                                    if (p < name_len(2'(i))) cn[i] = 1'b0;
                                end
                                else if (cn[i] && p < name_len(2'(i)) &&
                                         lb != name_char(2'(i), p))
                                    cn[i] = 1'b0;
                            end
                            cand_next = cn;
                            if (b == 8'h3A) phase_next = 4'd2;
                            else npos_next = (p < 5'd31) ? p + 5'd1 : p;
                            if (hstart && b == 8'h3A) npos_next = 5'd0;
                        end
                    end
                end
                STAGE_BODY:
                begin
                    r.part = PART_BODY;
                    if (rem_reg > '0) rem_next = rem_reg - 1'b1;
                    if (rem_reg <= 1) r.message_done = 1'b1;
                end
                default:
                begin
                    if (phase_reg == 4'd0 || phase_reg == 4'd1)
                    begin
                        if (b == 8'h3B) phase_next = 4'd2;
                        else if (b == CH_CR) phase_next = 4'd3;
                        else if (phase_reg == 4'd0 && b == 8'h2B) phase_next = 4'd1;
                        else if (dig >= 5'd16) err = ERR_DIGIT;
                        else
                        begin
                            num_next = hex_acc; phase_next = 4'd1;
                        end
                    end
                    else if (phase_reg == 4'd2)
                    begin
                        if (b == CH_CR) phase_next = 4'd3;
                    end
                    else if (phase_reg == 4'd3)
                    begin
                        if (b != CH_LF) err = ERR_NOLF;
                        else
                        begin
                            if (num_reg == '0) phase_next = 4'd7;
                            else
                            begin
                                rem_next = num_reg; phase_next = 4'd4;
                            end
                            num_next = '0;
                        end
                    end
                    else if (phase_reg == 4'd4)
                    begin
                        r.part = PART_BODY;
                        if (rem_reg > '0) rem_next = rem_reg - 1'b1;
                        if (rem_reg <= 1) phase_next = 4'd5;
                    end
                    else if (phase_reg == 4'd5 || phase_reg == 4'd7)
                    begin
                        if (b != CH_CR) err = ERR_NOLF;
                        else phase_next = phase_reg + 4'd1;
                    end
                    else if (phase_reg == 4'd6)
                    begin
                        if (b != CH_LF) err = ERR_NOLF;
                        else phase_next = '0;
                    end
                    else
                    begin
                        if (b != CH_LF) err = ERR_NOLF;
                        else r.message_done = 1'b1;
                    end
                end
            endcase
            // Finish a message: report close and clear per-message state
            if (err == ERR_NONE && r.message_done)
            begin
                r.close_required = close_next;
                stage_next = STAGE_FIRST; phase_next = '0; npos_next = '0;
                cand_next = 4'hF; vpos_next = '0; num_next = '0; rem_next = '0;
                code_next = '0; close_next = 1'b0; chunk_next = 1'b0; exp_next = 1'b0;
                cont_next = 1'b0; vbeg_next = 1'b0; neg_next = 1'b0;
            end
            // Latch an error and hold state
            if (err != ERR_NONE)
            begin
                r = '0; r.byte_out = b; r.error_code = err; err_next = err;
                stage_next = stage_reg; phase_next = phase_reg; npos_next = npos_reg;
                cand_next = cand_reg; vpos_next = vpos_reg; num_next = num_reg;
                rem_next = rem_reg; code_next = code_reg; close_next = close_reg;
                chunk_next = chunk_reg; exp_next = exp_reg; cont_next = cont_reg;
                vbeg_next = vbeg_reg; neg_next = neg_reg;
            end
        end
    end

    assign res = r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= STAGE_FIRST; phase_reg <= '0; npos_reg <= '0; cand_reg <= 4'hF;
            vpos_reg <= '0; num_reg <= '0; rem_reg <= '0; code_reg <= '0;
            close_reg <= 1'b0; chunk_reg <= 1'b0; exp_reg <= 1'b0; cont_reg <= 1'b0;
            vbeg_reg <= 1'b0; neg_reg <= 1'b0; err_reg <= ERR_NONE;
        end
        else if (step)
        begin
            stage_reg <= stage_next; phase_reg <= phase_next; npos_reg <= npos_next;
            cand_reg <= cand_next; vpos_reg <= vpos_next; num_reg <= num_next;
            rem_reg <= rem_next; code_reg <= code_next; close_reg <= close_next;
            chunk_reg <= chunk_next; exp_reg <= exp_next; cont_reg <= cont_next;
            vbeg_reg <= vbeg_next; neg_reg <= neg_next; err_reg <= err_next;
        end
    end
endmodule

### rtl/http_message_framer_unit.sv
`timescale 1ns / 1ps
// Input transfer to result passes the input register, then the result register.
// One byte per cycle unless the output stalls; parse state takes one step per byte.
// Reset (rst_n, asynchronous, active low): parser at the start of a first line,
// request_mode 1, continue_policy 0, error latch cleared, both stages empty.
module http_message_framer_unit
    import hmf_pkg::*;
#(
    parameter int LENGTH_BITS = LengthBitsDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // byte_out, part, header_kind, line_end,
                                        // status_code, message_done, close_required,
                                        // error_code (lowest first), zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [1:0]  cfg_data
);
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       out_vld_reg;
    result_t    out_reg;
    logic       request_mode_reg;
    logic [1:0] continue_policy_reg;
    result_t    res;
    logic       step, out_free;

    assign out_free      = !out_vld_reg || m_axis_tready;
    assign step          = in_vld_reg && out_free;
    assign s_axis_tready = !in_vld_reg || out_free;
    assign cfg_ready     = 1'b1;

    hmf_core #(.LENGTH_BITS(LENGTH_BITS)) u_core
    (
        .clk(clk), .rst_n(rst_n), .step(step), .b(in_byte_reg),
        .request_mode(request_mode_reg), .continue_policy(continue_policy_reg),
        .res(res)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_mode_reg    <= 1'b1;
            continue_policy_reg <= 2'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_REQUEST_MODE: request_mode_reg <= cfg_data[0];
                default:          continue_policy_reg <= cfg_data;
            endcase
        end
    end

    // Input register and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready) in_vld_reg <= s_axis_tvalid;
            if (out_free) out_vld_reg <= step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid) in_byte_reg <= s_axis_tdata;
        if (step) out_reg <= res;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {9'd0, out_reg.error_code, out_reg.close_required,
                            out_reg.message_done, out_reg.status_code, out_reg.line_end,
                            out_reg.header_kind, out_reg.part, out_reg.byte_out};

`ifndef SYNTHESIS
    a_close_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_reg.close_required |-> out_reg.message_done)
        else $error("close without message end");
    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && out_reg.error_code != ERR_NONE |-> out_reg.part == PART_FRAME)
        else $error("error result carries a part");
    a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> m_axis_tvalid)
        else $error("result lost");
`endif
endmodule
